>>> rtl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int NUM_WIDTH     = 33;
   localparam int DEN_WIDTH     = 31;
   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int SUM_WIDTH     = PROD_WIDTH + 1;
   localparam int EXT_WIDTH     = (SUM_WIDTH > NUM_WIDTH) ? SUM_WIDTH : NUM_WIDTH;
   localparam int CNT_WIDTH     = $clog2(SUM_WIDTH + 1);

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_SUB = 2'd1;
   localparam logic [1:0] FUNC_MUL = 2'd2;
   localparam logic [1:0] FUNC_DIV = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

   typedef struct packed {
      logic [1:0]                      func;
      logic signed [OPERAND_WIDTH-1:0] a_num;
      logic signed [OPERAND_WIDTH-1:0] a_den;
      logic signed [OPERAND_WIDTH-1:0] b_num;
      logic signed [OPERAND_WIDTH-1:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [NUM_WIDTH-1:0] res_num;
      logic [DEN_WIDTH-1:0]        res_den;
      logic [1:0]                  status;
   } rsp_type;

   typedef enum logic [1:0] {
      MUL_P0,
      MUL_P1,
      MUL_P2
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        sum_en;
      logic        gcd_pre;
      logic        gcd_step;
      logic        g_load;
      logic        div_step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic a_zero;
      logic both_even;
   } sts_type;

   function automatic logic [OPERAND_WIDTH-1:0] to_mag(input logic [OPERAND_WIDTH-1:0] raw);
      to_mag = raw[OPERAND_WIDTH-1] ? (OPERAND_WIDTH'(0) - raw) : raw;
   endfunction

endpackage

`default_nettype wire

>>> rtl/rational_arithmetic_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                          Direction  Payload
// req       req_valid, req_ready, req_data  in         func, a_num, a_den, b_num, b_den
// rsp       rsp_valid, rsp_ready, rsp_data  out        res_num, res_den, status
//
// One item at a time. An item takes 3 products on one shared multiplier, a
// binary gcd of shift/subtract steps, and a 33-step restoring division (both
// quotients at once).
// Bad denominators and division by zero go straight from S_MUL0 to S_DONE.
// Synchronous reset clears the controller and the result valid.
// A new item is taken while an earlier result waits in the output register;
// a finished item holds in the last state until that register is free.

module rational_arithmetic_unit_top (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  wire rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rau_dp u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/rau_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rau_dp (
   input  wire              clock,
   input  wire rau_pkg::req_type req_data,
   input  wire rau_pkg::cmd_type cmd,
   output rau_pkg::sts_type sts,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   logic [1:0]               func_ff;
   logic [OPERAND_WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [PROD_WIDTH-1:0]    p0_ff, p1_ff, p2_ff;
   logic [SUM_WIDTH-1:0]     ga_ff, gb_ff, gd_ff;
   logic [CNT_WIDTH-1:0]     k_ff;
   logic [SUM_WIDTH-1:0]     nq_ff, dq_ff, nr_ff, dr_ff;
   logic                     n_neg_ff, d_neg_ff;
   rsp_type                  rsp_ff;

   logic [OPERAND_WIDTH-1:0] an_mag, ad_mag, bn_mag, bd_mag;
   logic                     an_neg, ad_neg, bn_neg, bd_neg;
   logic [OPERAND_WIDTH-1:0] mx, my;
   logic [PROD_WIDTH-1:0]    prod;
   logic                     p0_neg, p1_neg, p2_neg;
   logic [SUM_WIDTH-1:0]     s0, s1, n_mag_in;
   logic                     n_neg_in;
   logic [SUM_WIDTH:0]       nt, dt, gx;
   logic [1:0]               status;
   logic                     res_neg;
   logic [EXT_WIDTH-1:0]     num_ext, num_sgn;
   rsp_type                  rsp_in;

   assign an_mag = to_mag(an_ff);
   assign ad_mag = to_mag(ad_ff);
   assign bn_mag = to_mag(bn_ff);
   assign bd_mag = to_mag(bd_ff);
   assign an_neg = an_ff[OPERAND_WIDTH-1];
   assign ad_neg = ad_ff[OPERAND_WIDTH-1];
   assign bn_neg = bn_ff[OPERAND_WIDTH-1];
   assign bd_neg = bd_ff[OPERAND_WIDTH-1];

   always_comb begin
      case (cmd.mul_sel)
         MUL_P0: begin
            mx = an_mag;
            my = (func_ff == FUNC_MUL) ? bn_mag : bd_mag;
         end
         MUL_P1: begin
            mx = bn_mag;
            my = ad_mag;
         end
         MUL_P2: begin
            mx = ad_mag;
            my = (func_ff == FUNC_DIV) ? bn_mag : bd_mag;
         end
         default: begin
            mx = an_mag;
            my = bd_mag;
         end
      endcase
   end

   assign prod = PROD_WIDTH'(mx) * PROD_WIDTH'(my);

   assign p0_neg = an_neg ^ ((func_ff == FUNC_MUL) ? bn_neg : bd_neg);
   assign p1_neg = bn_neg ^ ad_neg ^ (func_ff == FUNC_SUB);
   assign p2_neg = ad_neg ^ ((func_ff == FUNC_DIV) ? bn_neg : bd_neg);

   assign s0 = SUM_WIDTH'(p0_ff);
   assign s1 = SUM_WIDTH'(p1_ff);

   always_comb begin
      n_mag_in = s0;
      n_neg_in = p0_neg;
      if (func_ff == FUNC_ADD || func_ff == FUNC_SUB) begin
         if (p0_neg == p1_neg) begin
            n_mag_in = s0 + s1;
         end else if (s0 >= s1) begin
            n_mag_in = s0 - s1;
         end else begin
            n_mag_in = s1 - s0;
            n_neg_in = p1_neg;
         end
      end
   end

   assign gx = {1'b0, gd_ff};
   assign nt = {nr_ff, nq_ff[SUM_WIDTH-1]};
   assign dt = {dr_ff, dq_ff[SUM_WIDTH-1]};

   always_comb begin
      if (ad_ff == '0 || bd_ff == '0) begin
         status = STATUS_ZERO_DEN;
      end else if (func_ff == FUNC_DIV && bn_ff == '0) begin
         status = STATUS_DIV_ZERO;
      end else begin
         status = STATUS_OK;
      end
   end

   assign sts.err       = (status != STATUS_OK);
   assign sts.a_zero    = (ga_ff == '0);
   assign sts.both_even = !ga_ff[0] && !gb_ff[0];

   assign res_neg = (n_neg_ff != d_neg_ff) && (nq_ff != '0);
   assign num_ext = EXT_WIDTH'(nq_ff);
   assign num_sgn = res_neg ? (EXT_WIDTH'(0) - num_ext) : num_ext;

   always_comb begin
      rsp_in.status = status;
      if (status == STATUS_OK) begin
         rsp_in.res_num = num_sgn[NUM_WIDTH-1:0];
         rsp_in.res_den = DEN_WIDTH'(dq_ff);
      end else begin
         rsp_in.res_num = '0;
         rsp_in.res_den = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_data.func;
         an_ff   <= req_data.a_num;
         ad_ff   <= req_data.a_den;
         bn_ff   <= req_data.b_num;
         bd_ff   <= req_data.b_den;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_P0:  p0_ff <= prod;
            MUL_P1:  p1_ff <= prod;
            MUL_P2:  p2_ff <= prod;
            default: p0_ff <= prod;
         endcase
      end
      if (cmd.sum_en) begin
         ga_ff    <= n_mag_in;
         gb_ff    <= SUM_WIDTH'(p2_ff);
         k_ff     <= '0;
         nq_ff    <= n_mag_in;
         dq_ff    <= SUM_WIDTH'(p2_ff);
         n_neg_ff <= n_neg_in;
         d_neg_ff <= p2_neg;
      end
      if (cmd.gcd_pre) begin
         ga_ff <= ga_ff >> 1;
         gb_ff <= gb_ff >> 1;
         k_ff  <= k_ff + 1'b1;
      end
      if (cmd.gcd_step) begin
         if (!ga_ff[0]) begin
            ga_ff <= ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_ff <= gb_ff >> 1;
         end else if (ga_ff >= gb_ff) begin
            ga_ff <= (ga_ff - gb_ff) >> 1;
         end else begin
            gb_ff <= (gb_ff - ga_ff) >> 1;
         end
      end
      if (cmd.g_load) begin
         gd_ff <= gb_ff << k_ff;
         nr_ff <= '0;
         dr_ff <= '0;
      end
      if (cmd.div_step) begin
         if (nt >= gx) begin
            nr_ff <= SUM_WIDTH'(nt - gx);
            nq_ff <= {nq_ff[SUM_WIDTH-2:0], 1'b1};
         end else begin
            nr_ff <= SUM_WIDTH'(nt);
            nq_ff <= {nq_ff[SUM_WIDTH-2:0], 1'b0};
         end
         if (dt >= gx) begin
            dr_ff <= SUM_WIDTH'(dt - gx);
            dq_ff <= {dq_ff[SUM_WIDTH-2:0], 1'b1};
         end else begin
            dr_ff <= SUM_WIDTH'(dt);
            dq_ff <= {dq_ff[SUM_WIDTH-2:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/rau_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rau_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   input  wire rau_pkg::sts_type sts,
   output rau_pkg::cmd_type cmd
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_SUM,
      S_PRE,
      S_RUN,
      S_GLOAD,
      S_DIV,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.mul_sel  = MUL_P0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            if (sts.err) begin
               state_in = S_DONE;
            end else begin
               cmd.mul_en = 1'b1;
               state_in   = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_P1;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_P2;
            state_in    = S_SUM;
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = S_PRE;
         end
         S_PRE: begin
            if (sts.a_zero) begin
               state_in = S_GLOAD;
            end else if (sts.both_even) begin
               cmd.gcd_pre = 1'b1;
            end else begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (sts.a_zero) begin
               state_in = S_GLOAD;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_GLOAD: begin
            cmd.g_load = 1'b1;
            cnt_in     = CNT_WIDTH'(SUM_WIDTH);
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == CNT_WIDTH'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> tb/rational_arithmetic_unit_top_tb.sv
`timescale 1ns / 1ps

module rational_arithmetic_unit_top_tb;
   import rau_pkg::*;

   localparam int RANDOM_ITEMS = 1830;
   localparam int QUIET_ITEMS  = 200;
   localparam int DRAIN_AT     = 900;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 500;
   localparam int TAIL_CYCLES  = 150;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type answer;
   } fraction_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type          reduced_fractions[$];
   fraction_row_type fraction_table[$];
   int               fail_count = 0;
   int               accepted   = 0;
   bit               quiet      = 1'b0;
   rsp_type          want;

   rational_arithmetic_unit_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic rsp_type reduce_rational(input req_type r);
      longint  an, ad, bn, bd, n, d, x, y, t;
      bit      neg;
      rsp_type res;
      res = '0;
      an  = longint'($signed(r.a_num));
      ad  = longint'($signed(r.a_den));
      bn  = longint'($signed(r.b_num));
      bd  = longint'($signed(r.b_den));
      if (ad == 0 || bd == 0) begin
         res.status = STATUS_ZERO_DEN;
         return res;
      end
      if (r.func == FUNC_DIV && bn == 0) begin
         res.status = STATUS_DIV_ZERO;
         return res;
      end
      case (r.func)
         FUNC_ADD: begin
            n = an * bd + bn * ad;
            d = ad * bd;
         end
         FUNC_SUB: begin
            n = an * bd - bn * ad;
            d = ad * bd;
         end
         FUNC_MUL: begin
            n = an * bn;
            d = ad * bd;
         end
         default: begin
            n = an * bd;
            d = ad * bn;
         end
      endcase
      neg = ((n < 0) != (d < 0)) && n != 0;
      x   = (n < 0) ? -n : n;
      y   = (d < 0) ? -d : d;
      n   = x;
      d   = y;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      n = n / x;
      d = d / x;
      res.res_num = NUM_WIDTH'(neg ? -n : n);
      res.res_den = DEN_WIDTH'(d);
      res.status  = STATUS_OK;
      return res;
   endfunction

   function automatic logic signed [OPERAND_WIDTH-1:0] pick_operand();
      logic signed [OPERAND_WIDTH-1:0] v;
      case ($urandom_range(0, 4))
         0, 1: v = OPERAND_WIDTH'($urandom);
         2: v = OPERAND_WIDTH'(int'($urandom_range(0, 40)) - 20);
         3: begin
            case ($urandom_range(0, 5))
               0: v = OPERAND_WIDTH'(-32768);
               1: v = OPERAND_WIDTH'(32767);
               2: v = OPERAND_WIDTH'(-1);
               3: v = OPERAND_WIDTH'(1);
               4: v = OPERAND_WIDTH'(-32767);
               default: v = '0;
            endcase
         end
         default: v = OPERAND_WIDTH'((int'($urandom_range(0, 200)) - 100) * 12);
      endcase
      return v;
   endfunction

   function automatic logic signed [OPERAND_WIDTH-1:0] pick_denominator();
      logic signed [OPERAND_WIDTH-1:0] v;
      if ($urandom_range(0, 29) == 0)
         return '0;
      v = pick_operand();
      if (v == 0)
         v = OPERAND_WIDTH'($urandom_range(1, 32767));
      return v;
   endfunction

   function automatic req_type random_fraction_pair();
      req_type r;
      r.func  = 2'($urandom_range(0, 3));
      r.a_num = pick_operand();
      r.b_num = pick_operand();
      r.a_den = pick_denominator();
      r.b_den = pick_denominator();
      if (r.func == FUNC_DIV && $urandom_range(0, 19) == 0)
         r.b_num = '0;
      return r;
   endfunction

   task automatic add_row(input logic [1:0] f, input int an, input int ad, input int bn,
                          input int bd, input bit typed, input longint num,
                          input longint den, input logic [1:0] st);
      fraction_row_type row;
      row.item.func       = f;
      row.item.a_num      = OPERAND_WIDTH'(an);
      row.item.a_den      = OPERAND_WIDTH'(ad);
      row.item.b_num      = OPERAND_WIDTH'(bn);
      row.item.b_den      = OPERAND_WIDTH'(bd);
      row.typed           = typed;
      row.answer.res_num  = NUM_WIDTH'(num);
      row.answer.res_den  = DEN_WIDTH'(den);
      row.answer.status   = st;
      fraction_table.push_back(row);
   endtask

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic transfer_fraction(input req_type item, input rsp_type answer);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      reduced_fractions.push_back(answer);
      accepted++;
      @(negedge clock);
   endtask

   task automatic idle_burst();
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (reduced_fractions.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      req_type item;
      add_row(FUNC_ADD, 0, 5, 0, -7, 1'b1, 0, 1, STATUS_OK);
      add_row(FUNC_SUB, 3, 4, 3, 4, 1'b1, 0, 1, STATUS_OK);
      add_row(FUNC_ADD, 1, 0, 1, 1, 1'b1, 0, 0, STATUS_ZERO_DEN);
      add_row(FUNC_MUL, 1, 1, 1, 0, 1'b1, 0, 0, STATUS_ZERO_DEN);
      add_row(FUNC_DIV, 5, 3, 0, 1, 1'b1, 0, 0, STATUS_DIV_ZERO);
      add_row(FUNC_DIV, 1, 0, 0, 1, 1'b1, 0, 0, STATUS_ZERO_DEN);
      add_row(FUNC_DIV, 0, 0, 0, 0, 1'b1, 0, 0, STATUS_ZERO_DEN);
      add_row(FUNC_MUL, -32768, 1, -32768, 1, 1'b1, 1073741824, 1, STATUS_OK);
      add_row(FUNC_MUL, 32767, 1, 32767, 1, 1'b1, 1073676289, 1, STATUS_OK);
      add_row(FUNC_MUL, 1, -32768, 1, -32768, 1'b1, 1, 1073741824, STATUS_OK);
      add_row(FUNC_ADD, -32768, 1, -32768, 1, 1'b1, -65536, 1, STATUS_OK);
      add_row(FUNC_DIV, 1, 1, -1, 1, 1'b1, -1, 1, STATUS_OK);
      add_row(FUNC_SUB, -32768, 32767, 32767, -32768, 1'b0, 0, 0, STATUS_OK);
      add_row(FUNC_ADD, -32768, -32767, -32768, -32768, 1'b0, 0, 0, STATUS_OK);
      add_row(FUNC_SUB, 32767, -32768, -32768, 32767, 1'b0, 0, 0, STATUS_OK);
      add_row(FUNC_DIV, -32768, 32767, 32767, -32768, 1'b0, 0, 0, STATUS_OK);
      add_row(FUNC_ADD, 1, 2, 1, 3, 1'b0, 0, 0, STATUS_OK);
      add_row(FUNC_SUB, 1, 2, 1, 3, 1'b0, 0, 0, STATUS_OK);
      add_row(FUNC_MUL, 2, 3, 3, 4, 1'b0, 0, 0, STATUS_OK);
      add_row(FUNC_DIV, -4, 6, 2, -9, 1'b0, 0, 0, STATUS_OK);
      add_row(FUNC_ADD, 7, -3, 5, 6, 1'b0, 0, 0, STATUS_OK);
      add_row(FUNC_MUL, 5, -1, -3, -1, 1'b0, 0, 0, STATUS_OK);
      add_row(FUNC_DIV, -1, -1, -32768, -32768, 1'b0, 0, 0, STATUS_OK);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (fraction_table[i]) begin
         idle_burst();
         transfer_fraction(fraction_table[i].item,
                           fraction_table[i].typed ? fraction_table[i].answer
                                                   : reduce_rational(fraction_table[i].item));
      end
      wait_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == DRAIN_AT)
            wait_drained();
         if (i == RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;
         idle_burst();
         item = random_fraction_pair();
         transfer_fraction(item, reduce_rational(item));
      end
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (fail_count == 0)
         $display("rational_arithmetic_unit_top regression: pass");
      else
         $display("rational_arithmetic_unit_top regression: fail");
      $finish;
   end

   initial begin : receiver
      int unsigned stall;
      bit          held;
      stall = 0;
      held  = 1'b0;
      while (reset)
         @(negedge clock);
      forever begin
         if (!held && accepted >= HOLD_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
            @(negedge clock);
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall = $urandom_range(1, 14);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (reduced_fractions.size() == 0) begin
            $error("result transfer with nothing expected: res_num %0d res_den %0d status %0d",
                   rsp_data.res_num, rsp_data.res_den, rsp_data.status);
            fail_count++;
         end else begin
            want = reduced_fractions.pop_front();
            if (rsp_data.res_num !== want.res_num) begin
               $error("res_num: expected %0d, actual %0d", want.res_num, rsp_data.res_num);
               fail_count++;
            end
            if (rsp_data.res_den !== want.res_den) begin
               $error("res_den: expected %0d, actual %0d", want.res_den, rsp_data.res_den);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #6_000_000;
      $display("rational_arithmetic_unit_top regression: fail");
      $finish;
   end

endmodule
